// ----- src/ldst_pkg.sv -----
// Shared types, constants and helpers for the light direction servo tracker.
// No dependencies; every other file of the block refers to this package by scope.
package ldst_pkg;

    localparam int NUM_SENSORS        = 4;
    localparam int SAMPLES_PER_SENSOR = 8;   // power of two: the level is a right shift
    localparam int SAMPLE_BITS        = 8;
    localparam int FRAME_LEN          = SAMPLES_PER_SENSOR * NUM_SENSORS;

    localparam int LEVEL_SHIFT = $clog2(SAMPLES_PER_SENSOR);
    localparam int SUM_W       = SAMPLE_BITS + LEVEL_SHIFT;
    localparam int CNT_W       = $clog2(FRAME_LEN);
    localparam int POS_W       = $clog2(NUM_SENSORS);

    localparam int THRESH_W  = 8;
    localparam int CONFIRM_W = 4;
    localparam int PULSE_W   = 12;
    localparam int WIDTH_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [PULSE_W-1:0] PULSE_MIN = PULSE_W'(125);
    localparam logic [PULSE_W-1:0] PULSE_MAX = PULSE_W'(250);

    localparam logic [THRESH_W-1:0]  THRESH_RESET  = THRESH_W'(25);
    localparam logic [CONFIRM_W-1:0] CONFIRM_RESET = CONFIRM_W'(3);
    localparam logic [PULSE_W-1:0]   PULSE0_RESET  = PULSE_W'(125);
    localparam logic [PULSE_W-1:0]   PULSE1_RESET  = PULSE_W'(155);
    localparam logic [PULSE_W-1:0]   PULSE2_RESET  = PULSE_W'(188);
    localparam logic [PULSE_W-1:0]   PULSE3_RESET  = PULSE_W'(220);
    localparam logic [POS_W-1:0]     POS_RESET     = POS_W'(2);

    typedef logic [SAMPLE_BITS-1:0] level_t;
    typedef logic [POS_W-1:0]       pos_t;
    typedef logic [CONFIRM_W-1:0]   stable_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_CONFIRM   = 3'd1,
        CFG_PULSE0    = 3'd2,
        CFG_PULSE1    = 3'd3,
        CFG_PULSE2    = 3'd4,
        CFG_PULSE3    = 3'd5
    } cfg_index_t;

    // Frame decision inputs: levels, tracker state and settings
    typedef struct packed {
        logic [NUM_SENSORS-1:0][SAMPLE_BITS-1:0] levels;
        pos_t                                    position;
        stable_t                                 stable;
        logic [THRESH_W-1:0]                     threshold;
        logic [CONFIRM_W-1:0]                    confirm;
        logic [NUM_SENSORS-1:0][PULSE_W-1:0]     pulse_pos;
    } dec_in_t;

    // Frame decision outputs: next tracker state and result fields
    typedef struct packed {
        pos_t                position;
        stable_t             stable;
        logic                moved;
        pos_t                pick;
        level_t              max_level;
        logic [WIDTH_W-1:0]  pulse_width;
    } dec_out_t;

    function automatic logic [WIDTH_W-1:0] clamp_pulse(input logic [PULSE_W-1:0] p);
        logic [PULSE_W-1:0] c;
        c = p;
        if (p < PULSE_MIN)
        begin
            c = PULSE_MIN;
        end
        else if (p > PULSE_MAX)
        begin
            c = PULSE_MAX;
        end
        return c[WIDTH_W-1:0];
    endfunction

endpackage

// ----- src/ldst_if.sv -----
// Valid/ready channel interfaces for samples and frame results.
// Depends on ldst_pkg for field widths.
interface ldst_sample_if;
    logic                             valid;
    logic                             ready;
    logic [ldst_pkg::SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface ldst_result_if;
    logic                         valid;
    logic                         ready;
    logic [ldst_pkg::POS_W-1:0]   position;
    logic [ldst_pkg::WIDTH_W-1:0] pulse_width;
    logic                         moved;
    logic [ldst_pkg::POS_W-1:0]   pick;
    logic [ldst_pkg::SAMPLE_BITS-1:0] brightest_level;

    modport source (output valid, output position, output pulse_width, output moved,
                    output pick, output brightest_level, input ready);
    modport sink   (input valid, input position, input pulse_width, input moved,
                    input pick, input brightest_level, output ready);
endinterface

// ----- src/ldst_decide.sv -----
// End-of-frame decision: brightest pick, hold rule, confirmation counter, pulse.
// Depends on ldst_pkg for the decision structs and the pulse clamp.
module ldst_decide (
    input  ldst_pkg::dec_in_t  dec_in,
    output ldst_pkg::dec_out_t dec_out
);

    ldst_pkg::level_t  max_level;
    ldst_pkg::pos_t    raw_pick;
    ldst_pkg::pos_t    held_pick;
    ldst_pkg::pos_t    new_pos;
    ldst_pkg::stable_t stable_inc;
    ldst_pkg::level_t  spread;
    logic              all_close;

    // Brightest sensor, lowest index wins a tie
    always_comb
    begin
        max_level = dec_in.levels[0];
        raw_pick  = '0;
        for (int i = 1; i < ldst_pkg::NUM_SENSORS; i++)
        begin
            if (dec_in.levels[i] > max_level)
            begin
                max_level = dec_in.levels[i];
                raw_pick  = ldst_pkg::POS_W'(i);
            end
        end
    end

    // All levels close to the maximum: hold the current position
    always_comb
    begin
        all_close = 1'b1;
        spread    = '0;
        for (int i = 0; i < ldst_pkg::NUM_SENSORS; i++)
        begin
            spread = max_level - dec_in.levels[i];
            if (!(spread < dec_in.threshold))
            begin
                all_close = 1'b0;
            end
        end
    end

    assign held_pick  = (raw_pick != dec_in.position && all_close) ? dec_in.position : raw_pick;
    assign stable_inc = dec_in.stable + ldst_pkg::CONFIRM_W'(1);

    always_comb
    begin
        new_pos         = dec_in.position;
        dec_out.stable  = '0;
        dec_out.moved   = 1'b0;
        if (held_pick != dec_in.position)
        begin
            if (stable_inc >= dec_in.confirm)
            begin
                new_pos       = held_pick;
                dec_out.moved = 1'b1;
            end
            else
            begin
                dec_out.stable = stable_inc;
            end
        end
        dec_out.position    = new_pos;
        dec_out.pick        = held_pick;
        dec_out.max_level   = max_level;
        dec_out.pulse_width = ldst_pkg::clamp_pulse(dec_in.pulse_pos[new_pos]);
    end

endmodule

// ----- src/light_direction_servo_tracker_unit.sv -----
// Top level of the light direction servo tracker: sample accumulation and result output.
// Depends on ldst_pkg, the channel interfaces in ldst_if.sv and ldst_decide.
//
// The block takes one light sample per clock cycle with no gaps required: samples
// come in frames of 32, eight per sensor in sensor order 0 to 3. Each accepted
// sample is held in the input register, then is added into its sensor's
// sum; on the last sample of a frame the four averaged levels, the brightest pick,
// the hold rule and the confirmation counter are all resolved in that same cycle
// and one result request is loaded into the output register, so a result is
// presented once the frame's last sample has left the input register. Samples before
// the last of a frame never produce a result and never wait on the output side. A
// waiting result stalls the input only when the next last-of-frame sample needs
// the output register. Settings are written through the plain write port and take
// effect on the next frame decision; write them only while no frame is in progress.
module light_direction_servo_tracker_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    ldst_sample_if.sink                      samples,
    ldst_result_if.source                    results,
    input  logic                             cfg_write,
    input  logic [ldst_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ldst_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // Settings
    logic [ldst_pkg::THRESH_W-1:0]                           threshold_reg;
    logic [ldst_pkg::CONFIRM_W-1:0]                          confirm_reg;
    logic [ldst_pkg::NUM_SENSORS-1:0][ldst_pkg::PULSE_W-1:0] pulse_pos_reg;

    // Input register
    logic                             s1_valid_reg;
    logic [ldst_pkg::SAMPLE_BITS-1:0] s1_sample_reg;

    // Tracker state
    logic [ldst_pkg::CNT_W-1:0]                            counter_reg;
    logic [ldst_pkg::NUM_SENSORS-1:0][ldst_pkg::SUM_W-1:0] sums_reg;
    logic [ldst_pkg::NUM_SENSORS-1:0][ldst_pkg::SUM_W-1:0] sums_next;
    ldst_pkg::pos_t                                        position_reg;
    ldst_pkg::stable_t                                     stable_reg;

    // Output register
    logic                out_valid_reg;
    logic                out_valid_next;
    ldst_pkg::dec_out_t  out_reg;

    logic                       s1_last;
    logic                       s1_advance;
    logic                       out_taken;
    logic                       frame_done;
    logic [ldst_pkg::POS_W-1:0] s1_sensor;
    ldst_pkg::dec_in_t          dec_in;
    ldst_pkg::dec_out_t         dec_out;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= ldst_pkg::THRESH_RESET;
            confirm_reg      <= ldst_pkg::CONFIRM_RESET;
            pulse_pos_reg[0] <= ldst_pkg::PULSE0_RESET;
            pulse_pos_reg[1] <= ldst_pkg::PULSE1_RESET;
            pulse_pos_reg[2] <= ldst_pkg::PULSE2_RESET;
            pulse_pos_reg[3] <= ldst_pkg::PULSE3_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ldst_pkg::CFG_THRESHOLD: threshold_reg <= cfg_data[ldst_pkg::THRESH_W-1:0];
                ldst_pkg::CFG_CONFIRM:   confirm_reg   <= cfg_data[ldst_pkg::CONFIRM_W-1:0];
                ldst_pkg::CFG_PULSE0:    pulse_pos_reg[0] <= cfg_data;
                ldst_pkg::CFG_PULSE1:    pulse_pos_reg[1] <= cfg_data;
                ldst_pkg::CFG_PULSE2:    pulse_pos_reg[2] <= cfg_data;
                ldst_pkg::CFG_PULSE3:    pulse_pos_reg[3] <= cfg_data;
                default: ;  // unused index: drop the write
            endcase
        end
    end

    // Handshake: the last sample of a frame advances only if the output register
    // is free or being emptied this cycle; other samples always advance.
    assign s1_last       = (counter_reg == ldst_pkg::CNT_W'(ldst_pkg::FRAME_LEN - 1));
    assign out_taken     = out_valid_reg && results.ready;
    assign s1_advance    = s1_valid_reg && (!s1_last || !out_valid_reg || results.ready);
    assign frame_done    = s1_advance && s1_last;
    assign samples.ready = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            s1_valid_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            s1_sample_reg <= samples.sample;
        end
    end

    // Sensor of the held sample is the upper counter bits
    assign s1_sensor = counter_reg[ldst_pkg::CNT_W-1:ldst_pkg::LEVEL_SHIFT];

    // Add the held sample into its sensor's sum; levels come from the updated sums
    always_comb
    begin
        dec_in.position  = position_reg;
        dec_in.stable    = stable_reg;
        dec_in.threshold = threshold_reg;
        dec_in.confirm   = confirm_reg;
        dec_in.pulse_pos = pulse_pos_reg;
        for (int i = 0; i < ldst_pkg::NUM_SENSORS; i++)
        begin
            sums_next[i] = sums_reg[i];
            if (s1_sensor == ldst_pkg::POS_W'(i))
            begin
                sums_next[i] = sums_reg[i] + ldst_pkg::SUM_W'(s1_sample_reg);
            end
            dec_in.levels[i] = sums_next[i][ldst_pkg::SUM_W-1:ldst_pkg::LEVEL_SHIFT];
        end
    end

    ldst_decide u_decide (
        .dec_in  (dec_in),
        .dec_out (dec_out)
    );

    // Frame state: clear the sums and counter and take the new tracker state at the end of each frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg  <= '0;
            sums_reg     <= '0;
            position_reg <= ldst_pkg::POS_RESET;
            stable_reg   <= '0;
        end
        else if (frame_done)
        begin
            counter_reg  <= '0;
            sums_reg     <= '0;
            position_reg <= dec_out.position;
            stable_reg   <= dec_out.stable;
        end
        else if (s1_advance)
        begin
            counter_reg <= counter_reg + ldst_pkg::CNT_W'(1);
            sums_reg    <= sums_next;
        end
    end

    // Output register: load on a finished frame, drop once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (frame_done)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_taken)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_done)
        begin
            out_reg <= dec_out;
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.position        = out_reg.position;
    assign results.pulse_width     = out_reg.pulse_width;
    assign results.moved           = out_reg.moved;
    assign results.pick            = out_reg.pick;
    assign results.brightest_level = out_reg.max_level;

    // A new result only ever follows the last sample of a frame
    a_result_from_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(frame_done))
        else $error("result raised without a completed frame");

    // Never overwrite a result that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !results.ready) |-> !frame_done)
        else $error("pending result overwritten");

    // Frame end restarts the sample counter
    a_counter_restart: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |=> (counter_reg == '0))
        else $error("sample counter not restarted after frame");

    // Position changes exactly when a move is reported
    a_move_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |=> ((position_reg != $past(position_reg)) == out_reg.moved))
        else $error("position change and moved flag disagree");

    // The pulse value stays inside the servo range
    a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.pulse_width >= ldst_pkg::PULSE_MIN[ldst_pkg::WIDTH_W-1:0]
                        && out_reg.pulse_width <= ldst_pkg::PULSE_MAX[ldst_pkg::WIDTH_W-1:0]))
        else $error("pulse width outside servo range");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for the light direction servo tracker: frames of samples in, one
// result per frame out, each checked against a cycle-free predictor of the tracking rules.
// Depends on ldst_pkg, the channel interfaces of ldst_if.sv and the top level of the block.
`timescale 1ns / 100ps

module tb_top;

    // Quiet cycles (no request moving on either channel) tolerated before giving up
    localparam int STALL_LIMIT  = 2000;
    // Hold-off after the last result: the sample path is two registers deep
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        ldst_pkg::pos_t               position;
        logic [ldst_pkg::WIDTH_W-1:0] pulse_width;
        logic                         moved;
        ldst_pkg::pos_t               pick;
        ldst_pkg::level_t             brightest;
    } tracker_result_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_write;
    logic [ldst_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ldst_pkg::CFG_DATA_W-1:0] cfg_data;

    ldst_sample_if sample_ch ();
    ldst_result_if result_ch ();

    light_direction_servo_tracker_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (sample_ch),
        .results   (result_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state: running sums, position in the frame, tracker state, settings
    logic [ldst_pkg::SUM_W-1:0]     sensor_acc [ldst_pkg::NUM_SENSORS];
    int                             frame_fill;
    ldst_pkg::pos_t                 tracked_position;
    ldst_pkg::stable_t              differ_run;
    logic [ldst_pkg::THRESH_W-1:0]  hold_threshold;
    logic [ldst_pkg::CONFIRM_W-1:0] confirm_target;
    logic [ldst_pkg::PULSE_W-1:0]   pulse_setting [ldst_pkg::NUM_SENSORS];

    // Results still owed by the block, oldest first
    tracker_result_t pending_frames [$];

    int error_count;
    int send_idle_pct;
    int recv_stall_pct;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: stall the result channel at the rate chosen for the current phase
    always @(posedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Fold one accepted sample into the predictor; at the end of a frame resolve the
    // brightest sensor, the hold rule and the confirmation counter, and queue the result.
    function automatic void advance_tracker(input ldst_pkg::level_t value);
        ldst_pkg::level_t             levels [ldst_pkg::NUM_SENSORS];
        ldst_pkg::level_t             top;
        ldst_pkg::pos_t               choice;
        logic                         near;
        logic                         stepped;
        logic [ldst_pkg::PULSE_W-1:0] pw;
        tracker_result_t              res;
        int                           i;

        sensor_acc[frame_fill / ldst_pkg::SAMPLES_PER_SENSOR] += ldst_pkg::SUM_W'(value);
        frame_fill++;
        if (frame_fill < ldst_pkg::FRAME_LEN)
        begin
            return;
        end
        frame_fill = 0;

        for (i = 0; i < ldst_pkg::NUM_SENSORS; i++)
        begin
            levels[i]     = ldst_pkg::level_t'(sensor_acc[i] / ldst_pkg::SAMPLES_PER_SENSOR);
            sensor_acc[i] = '0;
        end

        // Strictly greater only, so a tie stays with the lower index
        top    = levels[0];
        choice = '0;
        for (i = 1; i < ldst_pkg::NUM_SENSORS; i++)
        begin
            if (levels[i] > top)
            begin
                top    = levels[i];
                choice = ldst_pkg::pos_t'(i);
            end
        end

        // Hold the current position when all four levels sit inside the threshold
        near = 1'b1;
        for (i = 0; i < ldst_pkg::NUM_SENSORS; i++)
        begin
            if (!((top - levels[i]) < hold_threshold))
            begin
                near = 1'b0;
            end
        end
        if (choice != tracked_position && near)
        begin
            choice = tracked_position;
        end

        // Any differing pick advances the counter; it need not be the same pick
        stepped = 1'b0;
        if (choice != tracked_position)
        begin
            differ_run = differ_run + ldst_pkg::CONFIRM_W'(1);
            if (differ_run >= confirm_target)
            begin
                tracked_position = choice;
                differ_run       = '0;
                stepped          = 1'b1;
            end
        end
        else
        begin
            differ_run = '0;
        end

        pw = pulse_setting[tracked_position];
        if (pw < ldst_pkg::PULSE_MIN)
        begin
            pw = ldst_pkg::PULSE_MIN;
        end
        else if (pw > ldst_pkg::PULSE_MAX)
        begin
            pw = ldst_pkg::PULSE_MAX;
        end

        res.position    = tracked_position;
        res.pulse_width = pw[ldst_pkg::WIDTH_W-1:0];
        res.moved       = stepped;
        res.pick        = choice;
        res.brightest   = top;
        pending_frames.push_back(res);
    endfunction

    // Offer one sample, idling first at the phase's rate, and hold it until taken.
    // Valid stays high across back-to-back requests so it is never dropped and
    // raised again within one step.
    task automatic send_sample(input ldst_pkg::level_t value);
        if ($urandom_range(99) < send_idle_pct)
        begin
            sample_ch.valid  <= 1'b0;
            sample_ch.sample <= ldst_pkg::level_t'($urandom_range(255));
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
            begin
                @(posedge clk);
            end
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= value;
        @(posedge clk);
        while (!sample_ch.ready)
        begin
            @(posedge clk);
        end
        advance_tracker(value);
    endtask

    // One whole frame: eight samples per sensor near its base level. A jitter of 255
    // or more gives plain noise instead.
    task automatic send_frame(input int b0, input int b1, input int b2, input int b3,
                              input int jitter);
        int s;
        int n;
        int b;
        int v;

        for (s = 0; s < ldst_pkg::NUM_SENSORS; s++)
        begin
            b = (s == 0) ? b0 : (s == 1) ? b1 : (s == 2) ? b2 : b3;
            for (n = 0; n < ldst_pkg::SAMPLES_PER_SENSOR; n++)
            begin
                if (jitter >= 255)
                begin
                    v = $urandom_range(255);
                end
                else
                begin
                    v = b + $urandom_range(jitter);
                    if (v > 255)
                    begin
                        v = 255;
                    end
                end
                send_sample(ldst_pkg::level_t'(v));
            end
        end
    endtask

    // Drop valid and wait until every owed result has come back, then let the
    // pipeline drain.
    task automatic settle();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_frames.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write one register; the predictor masks the data as the register width does
    task automatic put_reg(input ldst_pkg::cfg_index_t idx,
                           input logic [ldst_pkg::CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        unique case (idx)
            ldst_pkg::CFG_THRESHOLD: hold_threshold   = data[ldst_pkg::THRESH_W-1:0];
            ldst_pkg::CFG_CONFIRM:   confirm_target   = data[ldst_pkg::CONFIRM_W-1:0];
            ldst_pkg::CFG_PULSE0:    pulse_setting[0] = data[ldst_pkg::PULSE_W-1:0];
            ldst_pkg::CFG_PULSE1:    pulse_setting[1] = data[ldst_pkg::PULSE_W-1:0];
            ldst_pkg::CFG_PULSE2:    pulse_setting[2] = data[ldst_pkg::PULSE_W-1:0];
            ldst_pkg::CFG_PULSE3:    pulse_setting[3] = data[ldst_pkg::PULSE_W-1:0];
            default: ;
        endcase
    endtask

    // Bring the block to rest between frames, then rewrite every register
    task automatic apply_settings(input logic [ldst_pkg::CFG_DATA_W-1:0] thr,
                                  input logic [ldst_pkg::CFG_DATA_W-1:0] conf,
                                  input logic [ldst_pkg::CFG_DATA_W-1:0] p0,
                                  input logic [ldst_pkg::CFG_DATA_W-1:0] p1,
                                  input logic [ldst_pkg::CFG_DATA_W-1:0] p2,
                                  input logic [ldst_pkg::CFG_DATA_W-1:0] p3);
        settle();
        put_reg(ldst_pkg::CFG_THRESHOLD, thr);
        put_reg(ldst_pkg::CFG_CONFIRM, conf);
        put_reg(ldst_pkg::CFG_PULSE0, p0);
        put_reg(ldst_pkg::CFG_PULSE1, p1);
        put_reg(ldst_pkg::CFG_PULSE2, p2);
        put_reg(ldst_pkg::CFG_PULSE3, p3);
        cfg_write <= 1'b0;
    endtask

    // Reset settings: flat dark and flat bright frames are held at the centre, then a
    // steady bright sensor 0 needs three frames before the tracker moves there.
    task automatic test_reset_defaults();
        send_frame(0, 0, 0, 0, 0);
        send_frame(255, 255, 255, 255, 0);
        repeat (3) send_frame(255, 0, 0, 0, 0);
    endtask

    // From position 0: a tie between sensors 1 and 3 picks 1, a flat frame clears the
    // counter, and a spread one below the threshold is held while one equal to it is not.
    task automatic test_hold_and_tie();
        send_frame(10, 200, 0, 200, 0);
        send_frame(0, 0, 0, 0, 0);
        send_frame(100, 124, 100, 100, 0);
        send_frame(100, 125, 100, 100, 0);
        send_frame(0, 1, 0, 1, 7);
    endtask

    // Zero threshold and zero confirmation move on the first differing frame, even on
    // equal levels; the counter accepts changing picks; a full threshold holds.
    // Upper data bits above each register's width are set to show they are dropped.
    task automatic test_counter_rules();
        apply_settings(12'hF00, 12'hFF0, 12'd125, 12'd155, 12'd188, 12'd220);
        send_frame(0, 0, 0, 90, 0);
        send_frame(50, 50, 50, 50, 0);
        apply_settings(12'd10, 12'd2, 12'd125, 12'd155, 12'd188, 12'd220);
        send_frame(0, 255, 0, 0, 0);
        send_frame(0, 0, 0, 255, 0);
        apply_settings(12'd255, 12'd3, 12'd125, 12'd155, 12'd188, 12'd220);
        send_frame(200, 0, 0, 0, 0);
    endtask

    // Walk all four positions under pulse values below, at and above the clamp limits
    task automatic test_pulse_clamp();
        apply_settings(12'd0, 12'd1, 12'd0, 12'd124, 12'd251, 12'd4095);
        send_frame(255, 0, 0, 0, 0);
        send_frame(0, 255, 0, 0, 0);
        send_frame(0, 0, 255, 0, 0);
        send_frame(0, 0, 0, 255, 0);
        apply_settings(12'd0, 12'd1, 12'd125, 12'd250, 12'd2499, 12'd200);
        send_frame(0, 0, 255, 0, 0);
        send_frame(0, 255, 0, 0, 0);
        send_frame(255, 0, 0, 0, 0);
        send_frame(0, 0, 0, 255, 0);
    endtask

    // Random frames under each idling phase and three settings per phase, one of them
    // an extreme. Most frames have a favoured bright sensor so that moves happen; the
    // rest are near-flat frames that test the hold rule, or plain noise.
    task automatic test_random_tracking();
        int phase;
        int k;
        int f;
        int s;
        int favoured;
        int hi;
        int c;
        int kind;
        int jitter;
        int bases [ldst_pkg::NUM_SENSORS];
        logic [ldst_pkg::CFG_DATA_W-1:0] thr;
        logic [ldst_pkg::CFG_DATA_W-1:0] conf;
        logic [ldst_pkg::CFG_DATA_W-1:0] pulses [ldst_pkg::NUM_SENSORS];

        favoured = 0;
        for (phase = 0; phase < 4; phase++)
        begin
            unique case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            for (k = 0; k < 3; k++)
            begin
                if (k == 0)
                begin
                    thr  = ldst_pkg::CFG_DATA_W'($urandom_range(40, 5));
                    conf = ldst_pkg::CFG_DATA_W'($urandom_range(4, 1));
                end
                else if (k == 1)
                begin
                    thr  = phase[0] ? 12'd255 : 12'd0;
                    conf = phase[0] ? 12'd15 : 12'd1;
                end
                else
                begin
                    thr  = ldst_pkg::CFG_DATA_W'($urandom_range(4095));
                    conf = ldst_pkg::CFG_DATA_W'($urandom_range(4095));
                end
                for (s = 0; s < ldst_pkg::NUM_SENSORS; s++)
                begin
                    if ($urandom_range(3) == 0)
                    begin
                        pulses[s] = ldst_pkg::CFG_DATA_W'($urandom_range(4095));
                    end
                    else
                    begin
                        pulses[s] = ldst_pkg::CFG_DATA_W'($urandom_range(265, 110));
                    end
                end
                apply_settings(thr, conf, pulses[0], pulses[1], pulses[2], pulses[3]);

                for (f = 0; f < 3; f++)
                begin
                    if ($urandom_range(99) < 30)
                    begin
                        favoured = $urandom_range(3);
                    end
                    kind = $urandom_range(99);
                    if (kind < 60)
                    begin
                        hi = $urandom_range(248, 80);
                        for (s = 0; s < ldst_pkg::NUM_SENSORS; s++)
                        begin
                            bases[s] = (s == favoured) ? hi : $urandom_range(hi);
                        end
                        jitter = $urandom_range(7);
                    end
                    else if (kind < 85)
                    begin
                        c = $urandom_range(230);
                        for (s = 0; s < ldst_pkg::NUM_SENSORS; s++)
                        begin
                            bases[s] = c + $urandom_range(25);
                        end
                        jitter = $urandom_range(3);
                    end
                    else
                    begin
                        for (s = 0; s < ldst_pkg::NUM_SENSORS; s++)
                        begin
                            bases[s] = 0;
                        end
                        jitter = 255;
                    end
                    send_frame(bases[0], bases[1], bases[2], bases[3], jitter);

                    // Now and then hold the sender until the result side has caught up
                    if ($urandom_range(9) == 0)
                    begin
                        settle();
                    end
                end
            end
        end
    endtask

    // Compare each result request with the oldest expectation
    always @(posedge clk)
    begin : result_check
        tracker_result_t got;
        tracker_result_t want;

        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.position    = result_ch.position;
            got.pulse_width = result_ch.pulse_width;
            got.moved       = result_ch.moved;
            got.pick        = result_ch.pick;
            got.brightest   = result_ch.brightest_level;
            if (pending_frames.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result: expected none, got position=%0d pulse=%0d",
                         $time, got.position, got.pulse_width);
            end
            else
            begin
                want = pending_frames.pop_front();
                if (got !== want)
                begin
                    error_count++;
                    $display("%0t: expected position=%0d pulse=%0d moved=%0d pick=%0d level=%0d",
                             $time, want.position, want.pulse_width, want.moved, want.pick,
                             want.brightest);
                    $display("%0t: actual   position=%0d pulse=%0d moved=%0d pick=%0d level=%0d",
                             $time, got.position, got.pulse_width, got.moved, got.pick,
                             got.brightest);
                end
            end
        end
    end

    // Give up when no request has moved on either channel for too long
    initial
    begin : watchdog
        int quiet;

        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int i;

        // Drive every input to a known value before the first edge
        rst_n            <= 1'b0;
        sample_ch.valid  <= 1'b0;
        sample_ch.sample <= '0;
        cfg_write        <= 1'b0;
        cfg_index        <= ldst_pkg::CFG_THRESHOLD;
        cfg_data         <= '0;

        // Predictor starts from the reset state
        for (i = 0; i < ldst_pkg::NUM_SENSORS; i++)
        begin
            sensor_acc[i] = '0;
        end
        frame_fill       = 0;
        tracked_position = ldst_pkg::POS_RESET;
        differ_run       = '0;
        hold_threshold   = ldst_pkg::THRESH_RESET;
        confirm_target   = ldst_pkg::CONFIRM_RESET;
        pulse_setting[0] = ldst_pkg::PULSE0_RESET;
        pulse_setting[1] = ldst_pkg::PULSE1_RESET;
        pulse_setting[2] = ldst_pkg::PULSE2_RESET;
        pulse_setting[3] = ldst_pkg::PULSE3_RESET;
        error_count      = 0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_hold_and_tie();
        test_counter_rules();
        test_pulse_clamp();
        test_random_tracking();

        // Drain everything still owed, then report
        settle();
        if (error_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
